/* hdl/assert_macros.svh */
// assert_macros.svh: assertion macros shared by the split text console engine.
// Used by files that check their own logic; needs signals clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define STCE_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
   else $error(msg);

// Check that a condition is followed by another in the next cycle
`define STCE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
   else $error(msg);

`endif

/* hdl/stce_pkg.sv */
// stce_pkg: shared types, codes and default sizes of the split text console engine.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package stce_pkg;

   // Default geometry
   localparam int DEF_ROWS        = 25;
   localparam int DEF_COLUMNS     = 80;
   localparam int DEF_MAX_SCREENS = 4;

   // Fixed field widths of the channels
   localparam int CMD_W        = 2;
   localparam int CHAR_W       = 8;
   localparam int ROW_OUT_W    = 5;
   localparam int COL_OUT_W    = 7;
   localparam int SCREEN_OUT_W = 2;
   localparam int CSR_W        = 3;
   localparam int REQ_DATA_W   = 24;
   localparam int RSP_DATA_W   = 24;
   localparam int RSP_PAD_W    = RSP_DATA_W - CHAR_W - ROW_OUT_W - COL_OUT_W - SCREEN_OUT_W;

   // Request commands
   localparam logic [CMD_W-1:0] CMD_PUT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_NEXT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

   // Character codes with special meaning
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_SPACE     = 8'h20;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_SCR_RD,
      ST_SCR_WR,
      ST_BLANK,
      ST_FINISH
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;
      logic clear_step;
      logic exec;
      logic scr_read;
      logic scr_write;
      logic blank_write;
      logic finish;
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic clear_last;
      logic need_scroll;
      logic scr_end_col;
      logic scr_end_row;
      logic out_free;
   } ctl_sts_type;

endpackage

/* hdl/stce_ctrl.sv */
// stce_ctrl: sequencer of the split text console engine.
// Depends on stce_pkg and assert_macros.svh; drives the datapath through ctl_cmd_type.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stce_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output stce_pkg::ctl_cmd_type cmd,
   input  stce_pkg::ctl_sts_type sts
);

   stce_pkg::state_type state_ff, state_in;

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stce_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         stce_pkg::ST_CLEAR: begin
            if (sts.clear_last) state_in = stce_pkg::ST_IDLE;
         end
         stce_pkg::ST_IDLE: begin
            if (req_tvalid) state_in = stce_pkg::ST_EXEC;
         end
         stce_pkg::ST_EXEC: begin
            state_in = sts.need_scroll ? stce_pkg::ST_SCR_RD : stce_pkg::ST_FINISH;
         end
         stce_pkg::ST_SCR_RD: begin
            state_in = stce_pkg::ST_SCR_WR;
         end
         stce_pkg::ST_SCR_WR: begin
            if (sts.scr_end_col && sts.scr_end_row) state_in = stce_pkg::ST_BLANK;
            else                                    state_in = stce_pkg::ST_SCR_RD;
         end
         stce_pkg::ST_BLANK: begin
            if (sts.scr_end_col) state_in = stce_pkg::ST_FINISH;
         end
         stce_pkg::ST_FINISH: begin
            if (sts.out_free) state_in = stce_pkg::ST_IDLE;
         end
         default: begin
            state_in = stce_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands to the datapath
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         stce_pkg::ST_CLEAR:  cmd.clear_step = 1'b1;
         stce_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         stce_pkg::ST_EXEC:   cmd.exec        = 1'b1;
         stce_pkg::ST_SCR_RD: cmd.scr_read    = 1'b1;
         stce_pkg::ST_SCR_WR: cmd.scr_write   = 1'b1;
         stce_pkg::ST_BLANK:  cmd.blank_write = 1'b1;
         stce_pkg::ST_FINISH: cmd.finish      = sts.out_free;
         default: ;
      endcase
   end

   `STCE_ASSERT_NEXT(a_accept_exec, req_tvalid && req_tready, state_ff == stce_pkg::ST_EXEC, "accepted request not executed")
   `STCE_ASSERT_NEXT(a_finish_holds, state_ff == stce_pkg::ST_FINISH && !sts.out_free, state_ff == stce_pkg::ST_FINISH, "finish left while output busy")

endmodule

/* hdl/stce_datapath.sv */
// stce_datapath: character store, cursors, scroll counters and response register.
// Depends on stce_pkg and assert_macros.svh; sequenced by stce_ctrl.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stce_datapath #(
   parameter int ROWS        = stce_pkg::DEF_ROWS,
   parameter int COLUMNS     = stce_pkg::DEF_COLUMNS,
   parameter int MAX_SCREENS = stce_pkg::DEF_MAX_SCREENS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [stce_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic [stce_pkg::CMD_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [stce_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input  logic                                csr_wen,
   input  logic [stce_pkg::CSR_W-1:0]          csr_wdata,
   input  stce_pkg::ctl_cmd_type               cmd,
   output stce_pkg::ctl_sts_type               sts
);

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLUMNS);
   localparam int WW    = $clog2(COLUMNS + 1);
   localparam int SW    = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
   localparam int CNTW  = $clog2(MAX_SCREENS + 1);
   localparam int DEPTH = ROWS * COLUMNS;
   localparam int AW    = $clog2(DEPTH);
   localparam int OCH_W = stce_pkg::CHAR_W;
   localparam int ORW   = stce_pkg::ROW_OUT_W;
   localparam int OCW   = stce_pkg::COL_OUT_W;
   localparam int OSW   = stce_pkg::SCREEN_OUT_W;

   // Character store
   logic [OCH_W-1:0] store_mem [DEPTH];
   logic             mem_we, mem_re;
   logic [AW-1:0]    mem_waddr, mem_raddr;
   logic [OCH_W-1:0] mem_wdata;
   logic [OCH_W-1:0] rd_data_ff;

   // Control state
   logic [AW-1:0]   clr_addr_ff, clr_addr_in;
   logic [RW-1:0]   row_cur_ff [MAX_SCREENS];
   logic [RW-1:0]   row_cur_in [MAX_SCREENS];
   logic [CW-1:0]   col_cur_ff [MAX_SCREENS];
   logic [CW-1:0]   col_cur_in [MAX_SCREENS];
   logic [SW-1:0]   screen_ff, screen_in;
   logic [CNTW-1:0] count_ff, count_in;
   logic [WW-1:0]   width_ff, width_in;
   logic [CW-1:0]   base_ff, base_in;
   logic [RW-1:0]   scr_row_ff, scr_row_in;
   logic [CW-1:0]   scr_col_ff, scr_col_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // Request and response payload
   logic [stce_pkg::CMD_W-1:0] req_cmd_ff;
   logic [OCH_W-1:0]           req_char_ff;
   logic [ORW-1:0]             req_row_ff;
   logic [OCW-1:0]             req_col_ff;
   logic [OCH_W-1:0]           rsp_char_ff;
   logic [ORW-1:0]             rsp_row_ff;
   logic [OCW-1:0]             rsp_col_ff;
   logic [OSW-1:0]             rsp_screen_ff;

   // Derived values
   logic [WW-1:0]   width_tab [MAX_SCREENS];
   logic [CNTW-1:0] cfg_count;
   logic [CNTW-1:0] screen_inc;
   logic [RW-1:0]   act_row, bs_row;
   logic [CW-1:0]   act_col, bs_col;
   logic            at_last_row, at_last_col, at_origin, rd_in_range;
   logic [AW-1:0]   cur_addr, bs_addr, req_addr, scr_src_addr, scr_dst_addr, blank_addr;

   // Band width for each screen count
   for (genvar Sc = 1; Sc <= MAX_SCREENS; Sc++) begin : g_width
      assign width_tab[Sc-1] = WW'(COLUMNS / Sc);
   end

   // Clamp the written screen count into 1..MAX_SCREENS
   always_comb begin
      if (csr_wdata == '0) begin
         cfg_count = CNTW'(1);
      end else if (int'(csr_wdata) > MAX_SCREENS) begin
         cfg_count = CNTW'(MAX_SCREENS);
      end else begin
         cfg_count = CNTW'(csr_wdata);
      end
   end

   // Active cursor and its neighborhood
   assign act_row     = row_cur_ff[screen_ff];
   assign act_col     = col_cur_ff[screen_ff];
   assign at_last_row = (int'(act_row) == ROWS - 1);
   assign at_last_col = (int'(act_col) + 1 == int'(width_ff));
   assign at_origin   = (act_row == '0) && (act_col == '0);
   assign screen_inc  = CNTW'(screen_ff) + CNTW'(1);
   assign rd_in_range = (int'(req_row_ff) < ROWS) && (int'(req_col_ff) < COLUMNS);

   // Backspace target: previous cell, wrapping to the end of the previous row
   always_comb begin
      if (act_col != '0) begin
         bs_row = act_row;
         bs_col = act_col - CW'(1);
      end else begin
         bs_row = act_row - RW'(1);
         bs_col = CW'(width_ff - WW'(1));
      end
   end

   // Store addresses
   assign cur_addr     = AW'(int'(act_row) * COLUMNS + int'(base_ff) + int'(act_col));
   assign bs_addr      = AW'(int'(bs_row) * COLUMNS + int'(base_ff) + int'(bs_col));
   assign req_addr     = AW'(int'(req_row_ff) * COLUMNS + int'(req_col_ff));
   assign scr_src_addr = AW'((int'(scr_row_ff) + 1) * COLUMNS + int'(base_ff)
                             + int'(scr_col_ff));
   assign scr_dst_addr = AW'(int'(scr_row_ff) * COLUMNS + int'(base_ff) + int'(scr_col_ff));
   assign blank_addr   = AW'((ROWS - 1) * COLUMNS + int'(base_ff) + int'(scr_col_ff));

   // Execute the request and drive the store ports
   always_comb begin
      row_cur_in = row_cur_ff;
      col_cur_in = col_cur_ff;
      screen_in  = screen_ff;
      count_in   = count_ff;
      width_in   = width_ff;
      base_in    = base_ff;
      mem_we     = 1'b0;
      mem_waddr  = clr_addr_ff;
      mem_wdata  = stce_pkg::CHAR_SPACE;
      mem_re     = 1'b0;
      mem_raddr  = scr_src_addr;

      if (cmd.clear_step) mem_we = 1'b1;

      if (cmd.exec) begin
         case (req_cmd_ff)
            stce_pkg::CMD_PUT: begin
               if (req_char_ff == stce_pkg::CHAR_NEWLINE) begin
                  col_cur_in[screen_ff] = '0;
                  if (!at_last_row) row_cur_in[screen_ff] = act_row + RW'(1);
               end else if (req_char_ff == stce_pkg::CHAR_BACKSPACE) begin
                  if (!at_origin) begin
                     mem_we                = 1'b1;
                     mem_waddr             = bs_addr;
                     row_cur_in[screen_ff] = bs_row;
                     col_cur_in[screen_ff] = bs_col;
                  end
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_addr;
                  mem_wdata = req_char_ff;
                  if (at_last_col) begin
                     col_cur_in[screen_ff] = '0;
                     if (!at_last_row) row_cur_in[screen_ff] = act_row + RW'(1);
                  end else begin
                     col_cur_in[screen_ff] = act_col + CW'(1);
                  end
               end
            end
            stce_pkg::CMD_NEXT: begin
               if (screen_inc == count_ff) begin
                  screen_in = '0;
                  base_in   = '0;
               end else begin
                  screen_in = SW'(screen_inc);
                  base_in   = CW'(int'(base_ff) + int'(width_ff));
               end
            end
            stce_pkg::CMD_READ: begin
               if (rd_in_range) begin
                  mem_re    = 1'b1;
                  mem_raddr = req_addr;
               end
            end
            default: ;
         endcase
      end

      // Scroll: move each cell up one row, then blank the bottom row
      if (cmd.scr_read) mem_re = 1'b1;
      if (cmd.scr_write) begin
         mem_we    = 1'b1;
         mem_waddr = scr_dst_addr;
         mem_wdata = rd_data_ff;
      end
      if (cmd.blank_write) begin
         mem_we    = 1'b1;
         mem_waddr = blank_addr;
      end

      // Screen count write homes every cursor
      if (csr_wen) begin
         row_cur_in = '{default: '0};
         col_cur_in = '{default: '0};
         screen_in  = '0;
         base_in    = '0;
         count_in   = cfg_count;
         width_in   = width_tab[SW'(cfg_count - CNTW'(1))];
      end
   end

   // Advance clear and scroll counters
   always_comb begin
      clr_addr_in = clr_addr_ff;
      scr_row_in  = scr_row_ff;
      scr_col_in  = scr_col_ff;
      if (cmd.clear_step) clr_addr_in = clr_addr_ff + AW'(1);
      if (cmd.exec) begin
         scr_row_in = '0;
         scr_col_in = '0;
      end
      if (cmd.scr_write) begin
         if (sts.scr_end_col) begin
            scr_col_in = '0;
            scr_row_in = scr_row_ff + RW'(1);
         end else begin
            scr_col_in = scr_col_ff + CW'(1);
         end
      end
      if (cmd.blank_write) scr_col_in = scr_col_ff + CW'(1);
   end

   // Status to the controller
   assign sts.clear_last  = (int'(clr_addr_ff) == DEPTH - 1);
   assign sts.need_scroll = (req_cmd_ff == stce_pkg::CMD_PUT) && at_last_row
                            && ((req_char_ff == stce_pkg::CHAR_NEWLINE)
                                || ((req_char_ff != stce_pkg::CHAR_BACKSPACE) && at_last_col));
   assign sts.scr_end_col = (int'(scr_col_ff) + 1 == int'(width_ff));
   assign sts.scr_end_row = (int'(scr_row_ff) == ROWS - 2);
   assign sts.out_free    = !rsp_valid_ff || rsp_tready;

   // Hold response valid until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish)      rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   // Store write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[mem_waddr] <= mem_wdata;
      if (mem_re) rd_data_ff <= store_mem[mem_raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         row_cur_ff   <= '{default: '0};
         col_cur_ff   <= '{default: '0};
         screen_ff    <= '0;
         count_ff     <= CNTW'(1);
         width_ff     <= WW'(COLUMNS);
         base_ff      <= '0;
         scr_row_ff   <= '0;
         scr_col_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         row_cur_ff   <= row_cur_in;
         col_cur_ff   <= col_cur_in;
         screen_ff    <= screen_in;
         count_ff     <= count_in;
         width_ff     <= width_in;
         base_ff      <= base_in;
         scr_row_ff   <= scr_row_in;
         scr_col_ff   <= scr_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request, load the response
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_cmd_ff  <= req_tuser;
         req_char_ff <= req_tdata[7:0];
         req_row_ff  <= req_tdata[12:8];
         req_col_ff  <= req_tdata[19:13];
      end
      if (cmd.finish) begin
         rsp_char_ff   <= (req_cmd_ff == stce_pkg::CMD_READ && rd_in_range) ? rd_data_ff : '0;
         rsp_row_ff    <= ORW'(act_row);
         rsp_col_ff    <= OCW'(act_col);
         rsp_screen_ff <= OSW'(screen_ff);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{stce_pkg::RSP_PAD_W{1'b0}}, rsp_screen_ff, rsp_col_ff, rsp_row_ff,
                        rsp_char_ff};

   `STCE_ASSERT(a_cursor_in_band, int'(act_col) < int'(width_ff) && int'(act_row) < ROWS, "cursor outside its band")
   `STCE_ASSERT(a_screen_below_count, CNTW'(screen_ff) < count_ff, "active screen not below screen count")

endmodule

/* hdl/split_text_console_engine_core.sv */
// split_text_console_engine_core: top level of the split text console engine.
// Depends on stce_pkg, stce_ctrl and stce_datapath.
//
//   channel  direction  handshake            payload
//   req_     in         req_tvalid/tready    tuser command; tdata char, row, column
//   rsp_     out        rsp_tvalid/tready    tdata read char, cursor row/col, screen
//   csr_     in         csr_wen              csr_wdata screen count
//
// A request is accepted in the idle step and its response is registered after the execute
// and finish steps; no new request is accepted before the previous one has left the finish
// step. A move past the bottom row adds a band scroll, which copies each cell of the band
// one row up in alternating read and write steps and then blanks the band's bottom row.
// After reset a clear pass writes spaces into all ROWS*COLUMNS cells before the first
// request is accepted; screen count writes are taken meanwhile.
// A request is accepted while an earlier response still waits; a stalled response
// holds the next one in its finish step.
`timescale 1ns / 1ps

module split_text_console_engine_core #(
   parameter int ROWS        = stce_pkg::DEF_ROWS,
   parameter int COLUMNS     = stce_pkg::DEF_COLUMNS,
   parameter int MAX_SCREENS = stce_pkg::DEF_MAX_SCREENS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // char_code[7:0], read_row[12:8], read_column[19:13], zero[23:20]
   input  logic [stce_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [stce_pkg::CMD_W-1:0]      req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // read_char[7:0], cursor_row[12:8], cursor_column[19:13], screen_index[21:20], zero[23:22]
   output logic [stce_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_wen,
   input  logic [stce_pkg::CSR_W-1:0]      csr_wdata
);

   stce_pkg::ctl_cmd_type cmd;
   stce_pkg::ctl_sts_type sts;

   // Sequencer
   stce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Store, cursors and response register
   stce_datapath #(
      .ROWS        (ROWS),
      .COLUMNS     (COLUMNS),
      .MAX_SCREENS (MAX_SCREENS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

/* tb/split_text_console_engine_core_test.sv */
// Self-checking testbench for split_text_console_engine_core: it streams console requests,
// predicts every response with its own model of the banded store, and checks each field.
// Depends on stce_pkg and the engine RTL; no files, arguments or seeds are read.
`timescale 1ns / 1ps

module split_text_console_engine_core_test;

   localparam int ROWS          = stce_pkg::DEF_ROWS;
   localparam int COLUMNS       = stce_pkg::DEF_COLUMNS;
   localparam int MAX_SCREENS   = stce_pkg::DEF_MAX_SCREENS;
   localparam int CMD_W         = stce_pkg::CMD_W;
   localparam int CHAR_W        = stce_pkg::CHAR_W;
   localparam int ROW_OUT_W     = stce_pkg::ROW_OUT_W;
   localparam int COL_OUT_W     = stce_pkg::COL_OUT_W;
   localparam int SCREEN_OUT_W  = stce_pkg::SCREEN_OUT_W;
   localparam int REQ_DATA_W    = stce_pkg::REQ_DATA_W;
   localparam int RSP_DATA_W    = stce_pkg::RSP_DATA_W;
   localparam int CSR_W         = stce_pkg::CSR_W;
   localparam int SETTLE_CYCLES = 4;
   localparam int END_CYCLES    = 16;
   localparam int unsigned CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic [CMD_W-1:0]     command;
      logic [CHAR_W-1:0]    code;
      logic [ROW_OUT_W-1:0] row;
      logic [COL_OUT_W-1:0] column;
   } console_req_type;

   typedef struct packed {
      logic [CHAR_W-1:0]       read_char;
      logic [ROW_OUT_W-1:0]    cursor_row;
      logic [COL_OUT_W-1:0]    cursor_column;
      logic [SCREEN_OUT_W-1:0] screen_index;
   } console_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]      req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wen = 1'b0;
   logic [CSR_W-1:0]      csr_wdata = '0;

   // Pending requests, in-flight request and expected responses
   console_req_type console_requests_q[$];
   console_req_type req_shown;
   console_rsp_type console_reports_q[$];
   console_rsp_type report_due;

   // Shadow copy of the console state
   logic [CHAR_W-1:0] shadow_cells [ROWS*COLUMNS];
   int unsigned       band_row [MAX_SCREENS];
   int unsigned       band_col [MAX_SCREENS];
   int unsigned       active_screen;
   int unsigned       screen_total;

   bit          idling_on = 1'b1;
   int          req_gap = 0;
   int          rsp_stall = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   split_text_console_engine_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Scroll the band up one row and blank its last row
   function automatic void scroll_band(input int unsigned base, input int unsigned width);
      int unsigned r;
      int unsigned c;
      for (r = 0; r + 1 < ROWS; r++)
         for (c = 0; c < width; c++)
            shadow_cells[r*COLUMNS + base + c] = shadow_cells[(r+1)*COLUMNS + base + c];
      for (c = 0; c < width; c++)
         shadow_cells[(ROWS-1)*COLUMNS + base + c] = stce_pkg::CHAR_SPACE;
   endfunction

   function automatic void advance_row(input int unsigned s, input int unsigned base,
                                       input int unsigned width);
      if (band_row[s] < ROWS - 1)
         band_row[s]++;
      else
         scroll_band(base, width);
   endfunction

   // Home every cursor and clamp the screen count into range
   function automatic void apply_screen_count(input logic [CSR_W-1:0] value);
      int unsigned n;
      int unsigned s;
      n = value;
      if (n == 0)
         n = 1;
      if (n > MAX_SCREENS)
         n = MAX_SCREENS;
      screen_total = n;
      for (s = 0; s < MAX_SCREENS; s++) begin
         band_row[s] = 0;
         band_col[s] = 0;
      end
      active_screen = 0;
   endfunction

   // Apply one request to the shadow console and return the response it yields
   function automatic console_rsp_type console_step(input console_req_type req);
      console_rsp_type rsp;
      int unsigned  width;
      int unsigned  base;
      int unsigned  s;
      width = COLUMNS / screen_total;
      s = active_screen;
      base = s * width;
      rsp.read_char = '0;
      case (req.command)
         stce_pkg::CMD_PUT: begin
            if (req.code == stce_pkg::CHAR_NEWLINE) begin
               band_col[s] = 0;
               advance_row(s, base, width);
            end else if (req.code == stce_pkg::CHAR_BACKSPACE) begin
               // nothing moves at the band origin
               if (band_row[s] != 0 || band_col[s] != 0) begin
                  if (band_col[s] > 0) begin
                     band_col[s]--;
                  end else begin
                     band_col[s] = width - 1;
                     band_row[s]--;
                  end
                  shadow_cells[band_row[s]*COLUMNS + base + band_col[s]] = stce_pkg::CHAR_SPACE;
               end
            end else begin
               shadow_cells[band_row[s]*COLUMNS + base + band_col[s]] = req.code;
               band_col[s]++;
               if (band_col[s] >= width) begin
                  band_col[s] = 0;
                  advance_row(s, base, width);
               end
            end
         end
         stce_pkg::CMD_NEXT: active_screen = (active_screen + 1) % screen_total;
         stce_pkg::CMD_READ: begin
            if (req.row < ROWS && req.column < COLUMNS)
               rsp.read_char = shadow_cells[req.row*COLUMNS + req.column];
         end
         default: ;
      endcase
      rsp.cursor_row    = ROW_OUT_W'(band_row[active_screen]);
      rsp.cursor_column = COL_OUT_W'(band_col[active_screen]);
      rsp.screen_index  = SCREEN_OUT_W'(active_screen);
      return rsp;
   endfunction

   function automatic void queue_request(input logic [CMD_W-1:0] command,
                                         input logic [CHAR_W-1:0] code,
                                         input logic [ROW_OUT_W-1:0] row,
                                         input logic [COL_OUT_W-1:0] column);
      console_req_type req;
      req.command = command;
      req.code    = code;
      req.row     = row;
      req.column  = column;
      console_requests_q.push_back(req);
   endfunction

   // Put request with random don't-care location fields
   function automatic void queue_put(input logic [CHAR_W-1:0] code);
      queue_request(stce_pkg::CMD_PUT, code, ROW_OUT_W'($urandom), COL_OUT_W'($urandom));
   endfunction

   function automatic logic [CHAR_W-1:0] printable_code();
      logic [CHAR_W-1:0] c;
      c = CHAR_W'($urandom_range(0, 255));
      while (c == stce_pkg::CHAR_NEWLINE || c == stce_pkg::CHAR_BACKSPACE)
         c = CHAR_W'($urandom_range(0, 255));
      return c;
   endfunction

   // Queue one run of related requests shaped by the current cursor; return the count it adds toward the phase target
   function automatic int queue_segment();
      int unsigned width;
      int unsigned base;
      int unsigned n;
      int unsigned i;
      int unsigned pick;
      int unsigned r;
      int unsigned c;
      width = COLUMNS / screen_total;
      base  = active_screen * width;
      pick  = $urandom_range(0, 99);
      if (pick < 12) begin
         // run the active cursor past the bottom row
         n = ROWS - 1 - band_row[active_screen] + $urandom_range(1, 3);
         for (i = 0; i < n; i++)
            queue_put(stce_pkg::CHAR_NEWLINE);
      end else if (pick < 30) begin
         n = $urandom_range(1, 4);
         for (i = 0; i < n; i++)
            queue_put(stce_pkg::CHAR_NEWLINE);
      end else if (pick < 56) begin
         // a line of text, sometimes past the band edge, with the odd correction
         n = $urandom_range(1, width + 1);
         for (i = 0; i < n; i++)
            queue_put($urandom_range(0, 9) == 0 ? stce_pkg::CHAR_BACKSPACE : printable_code());
         if ($urandom_range(0, 9) < 4) begin
            queue_put(stce_pkg::CHAR_NEWLINE);
            n++;
         end
      end else if (pick < 66) begin
         // backspaces, often right after a newline to cross back a row
         n = $urandom_range(1, 4);
         if ($urandom_range(0, 1) == 1) begin
            queue_put(stce_pkg::CHAR_NEWLINE);
            n++;
         end
         for (i = 0; i < n; i++)
            queue_put(stce_pkg::CHAR_BACKSPACE);
      end else if (pick < 86) begin
         n = $urandom_range(1, 3);
         for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
               // the cell just written by the active screen
               r = band_row[active_screen];
               c = base + (band_col[active_screen] > 0 ? band_col[active_screen] - 1 : 0);
            end else if (pick < 85) begin
               r = $urandom_range(0, ROWS - 1);
               c = $urandom_range(0, COLUMNS - 1);
            end else begin
               r = $urandom_range(0, 31);
               c = $urandom_range(0, 127);
            end
            queue_request(stce_pkg::CMD_READ, CHAR_W'($urandom), ROW_OUT_W'(r),
                          COL_OUT_W'(c));
         end
      end else if (pick < 94) begin
         n = 1;
         queue_request(stce_pkg::CMD_NEXT, CHAR_W'($urandom), ROW_OUT_W'($urandom),
                       COL_OUT_W'($urandom));
      end else if (pick < 97) begin
         // no-op requests change nothing and do not count
         n = 0;
         queue_request(stce_pkg::CMD_NOP, CHAR_W'($urandom), ROW_OUT_W'($urandom),
                       COL_OUT_W'($urandom));
      end else begin
         n = 1;
         queue_request(CMD_W'($urandom), CHAR_W'($urandom), ROW_OUT_W'($urandom),
                       COL_OUT_W'($urandom));
      end
      return n;
   endfunction

   task automatic check_field(input string field, input int unsigned expected,
                              input int unsigned actual);
      if (expected != actual) begin
         $display("%0t: %s expected %0h, got %0h", $time, field, expected, actual);
         mismatch_count++;
      end
   endtask

   // Wait until no request is pending and every response has come back
   task automatic wait_drained();
      @(negedge clock);
      while (console_requests_q.size() != 0 || req_tvalid || console_reports_q.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_screen_count(input logic [CSR_W-1:0] value);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      apply_screen_count(value);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic run_random_phase(input logic [CSR_W-1:0] count, input int target);
      int issued;
      issued = 0;
      wait_drained();
      write_screen_count(count);
      while (issued < target) begin
         @(negedge clock);
         while (console_requests_q.size() != 0)
            @(negedge clock);
         issued += queue_segment();
      end
   endtask

   // Driver: present queued requests, record the prediction on each accept
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready)
            console_reports_q.push_back(console_step(req_shown));
         if (!req_tvalid || req_tready) begin
            if (req_gap != 0) begin
               req_gap    <= req_gap - 1;
               req_tvalid <= 1'b0;
            end else if (console_requests_q.size() == 0) begin
               req_tvalid <= 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
               req_gap    <= $urandom_range(0, 6);
               req_tvalid <= 1'b0;
            end else begin
               req_shown = console_requests_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {4'b0, req_shown.column, req_shown.row, req_shown.code};
               req_tuser  <= req_shown.command;
            end
         end
      end
   end

   // Monitor: compare each response with the oldest prediction, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall  <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (console_reports_q.size() == 0) begin
               $display("%0t: response expected none, got %h", $time, rsp_tdata);
               mismatch_count++;
            end else begin
               report_due = console_reports_q.pop_front();
               check_field("read_char", report_due.read_char, rsp_tdata[7:0]);
               check_field("cursor_row", report_due.cursor_row, rsp_tdata[12:8]);
               check_field("cursor_column", report_due.cursor_column, rsp_tdata[19:13]);
               check_field("screen_index", report_due.screen_index, rsp_tdata[21:20]);
            end
         end
         if (rsp_stall != 0) begin
            rsp_stall  <= rsp_stall - 1;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_stall  <= $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Hold reset for the first cycles only
   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Stop a hung run
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int unsigned i;
      for (i = 0; i < ROWS*COLUMNS; i++)
         shadow_cells[i] = stce_pkg::CHAR_SPACE;
      apply_screen_count(3'd1);
      @(negedge clock);
      while (reset)
         @(negedge clock);

      // Directed: reset contents, read bounds, origin and column-zero backspace
      queue_request(stce_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
      queue_request(stce_pkg::CMD_READ, 8'hFF, 5'd24, 7'd79);
      queue_request(stce_pkg::CMD_READ, 8'h00, 5'd31, 7'd127);
      queue_request(stce_pkg::CMD_READ, 8'h00, 5'd25, 7'd0);
      queue_request(stce_pkg::CMD_READ, 8'h00, 5'd0, 7'd80);
      queue_put(stce_pkg::CHAR_BACKSPACE);
      queue_put(8'h00);
      queue_put(8'hFF);
      queue_request(stce_pkg::CMD_READ, 8'h00, 5'd0, 7'd0);
      queue_request(stce_pkg::CMD_READ, 8'h00, 5'd0, 7'd1);
      queue_put(stce_pkg::CHAR_NEWLINE);
      queue_put(stce_pkg::CHAR_BACKSPACE);
      queue_request(stce_pkg::CMD_NOP, 8'hFF, 5'd31, 7'd127);
      queue_request(stce_pkg::CMD_NEXT, 8'h00, 5'd0, 7'd0);

      // Directed: four bands, screen wrap, write into a side band
      wait_drained();
      write_screen_count(3'd4);
      @(negedge clock);
      queue_request(stce_pkg::CMD_NEXT, 8'h00, 5'd0, 7'd0);
      queue_put(8'h41);
      queue_request(stce_pkg::CMD_NEXT, 8'h00, 5'd0, 7'd0);
      queue_request(stce_pkg::CMD_NEXT, 8'h00, 5'd0, 7'd0);
      queue_request(stce_pkg::CMD_NEXT, 8'h00, 5'd0, 7'd0);
      queue_request(stce_pkg::CMD_READ, 8'h00, 5'd0, 7'd20);

      // Random phases across screen counts, out-of-range values included
      run_random_phase(3'd0, 15);
      run_random_phase(3'd2, 15);
      run_random_phase(3'd7, 15);
      run_random_phase(3'd3, 15);
      wait_drained();
      idling_on = 1'b0;
      run_random_phase(3'd1, 15);

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && console_reports_q.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
